@@ sv/bxrd_pkg.sv @@
// ----------------------------------------------------------------------------
// bxrd_pkg
// Shared constants, types and the generator step function for the banked
// xorshift range draw core.
// ----------------------------------------------------------------------------
package bxrd_pkg;

   localparam int STREAM_COUNT_DEF = 32;

   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 5;
   localparam int STATE_W = 64;
   localparam int VALUE_W = 32;

   localparam logic [FUNC_W-1:0] FUNC_SEED = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DRAW = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

   localparam int SHIFT_A = 13;
   localparam int SHIFT_B = 7;
   localparam int SHIFT_C = 17;

   // A draw gives up after 2**TRY_W steps.
   localparam int TRY_W = 16;

   typedef struct packed {
      logic accept;
      logic seed_wr;
      logic load;
      logic step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] req_func;
      logic              req_index_ok;
      logic              hit;
      logic              last_try;
   } status_type;

   function automatic logic [STATE_W-1:0] advance(input logic [STATE_W-1:0] s);
      logic [STATE_W-1:0] t;
      t = s ^ (s << SHIFT_A);
      t = t ^ (t >> SHIFT_B);
      t = t ^ (t << SHIFT_C);
      return t;
   endfunction

endpackage

@@ sv/bxrd_ctrl.sv @@
// ----------------------------------------------------------------------------
// bxrd_ctrl
// Sequencer for the draw core. It accepts one request word at a time, runs
// the load and step phases and owns the valid flag of the response register.
// ----------------------------------------------------------------------------
module bxrd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bxrd_pkg::status_type status,
   output bxrd_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_STEP = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       draw_ff, draw_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      draw_in      = draw_ff;
      cmd          = '0;
      cmd.accept   = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept && status.req_index_ok) begin
               case (status.req_func)
                  bxrd_pkg::FUNC_SEED: begin
                     cmd.seed_wr = 1'b1;
                  end
                  bxrd_pkg::FUNC_DRAW: begin
                     draw_in  = 1'b1;
                     state_in = ST_LOAD;
                  end
                  bxrd_pkg::FUNC_READ: begin
                     draw_in  = 1'b0;
                     state_in = ST_LOAD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = draw_ff ? ST_STEP : ST_OUT;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (status.hit) begin
               state_in = ST_OUT;
            end else if (status.last_try) begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         draw_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         draw_ff      <= draw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/bxrd_dpath.sv @@
// ----------------------------------------------------------------------------
// bxrd_dpath
// Datapath of the draw core: the bank of generator states, the working
// state register with its step logic and range test, and the response word.
// ----------------------------------------------------------------------------
module bxrd_dpath #(
   parameter int STREAM_COUNT = bxrd_pkg::STREAM_COUNT_DEF
) (
   input  logic                          clock,
   input  logic [bxrd_pkg::FUNC_W-1:0]   req_func,
   input  logic [bxrd_pkg::INDEX_W-1:0]  req_stream_index,
   input  logic [bxrd_pkg::STATE_W-1:0]  req_seed_value,
   input  logic [bxrd_pkg::VALUE_W-1:0]  req_range_low,
   input  logic [bxrd_pkg::VALUE_W-1:0]  req_range_high,
   input  logic [bxrd_pkg::VALUE_W-1:0]  req_value_mask,
   input  bxrd_pkg::cmd_type             cmd,
   output bxrd_pkg::status_type          status,
   output logic [bxrd_pkg::VALUE_W-1:0]  rsp_drawn_value,
   output logic [bxrd_pkg::STATE_W-1:0]  rsp_state_readback
);

   localparam int ADDR_W = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
   localparam int EXT_W  = (ADDR_W > bxrd_pkg::INDEX_W) ? ADDR_W : bxrd_pkg::INDEX_W;

   logic [bxrd_pkg::STATE_W-1:0] mem [STREAM_COUNT];

   logic [EXT_W:0]                 idx_ext;
   logic [ADDR_W-1:0]              req_addr;
   logic [ADDR_W-1:0]              addr_ff;
   logic [bxrd_pkg::VALUE_W-1:0]   low_ff;
   logic [bxrd_pkg::VALUE_W-1:0]   high_ff;
   logic [bxrd_pkg::VALUE_W-1:0]   mask_ff;
   logic [bxrd_pkg::STATE_W-1:0]   mem_q_ff;
   logic [bxrd_pkg::STATE_W-1:0]   state_ff, state_in;
   logic [bxrd_pkg::VALUE_W-1:0]   value_ff, value_in;
   logic [bxrd_pkg::TRY_W-1:0]     try_ff, try_in;
   logic [bxrd_pkg::STATE_W-1:0]   step_next;
   logic [bxrd_pkg::VALUE_W-1:0]   step_value;
   logic                           hit;
   logic                           last_try;
   logic [bxrd_pkg::VALUE_W-1:0]   rsp_value_ff;
   logic [bxrd_pkg::STATE_W-1:0]   rsp_state_ff;

   assign idx_ext  = (EXT_W+1)'(req_stream_index);
   assign req_addr = idx_ext[ADDR_W-1:0];

   assign step_next  = bxrd_pkg::advance(state_ff);
   assign step_value = step_next[bxrd_pkg::VALUE_W-1:0] & mask_ff;
   assign hit        = (low_ff <= step_value) && (step_value <= high_ff);
   assign last_try   = (try_ff == {bxrd_pkg::TRY_W{1'b1}});

   always_comb begin
      status.req_func     = req_func;
      status.req_index_ok = idx_ext < (EXT_W+1)'(STREAM_COUNT);
      status.hit          = hit;
      status.last_try     = last_try;
   end

   always_ff @(posedge clock) begin
      if (cmd.seed_wr) begin
         mem[req_addr] <= req_seed_value;
      end else if (cmd.step && (hit || last_try)) begin
         mem[addr_ff] <= step_next;
      end
      if (cmd.accept) begin
         mem_q_ff <= mem[req_addr];
      end
   end

   always_comb begin
      state_in = state_ff;
      value_in = value_ff;
      try_in   = try_ff;
      if (cmd.load) begin
         state_in = mem_q_ff;
         value_in = '0;
         try_in   = '0;
      end else if (cmd.step) begin
         state_in = step_next;
         value_in = step_value;
         try_in   = try_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         addr_ff <= req_addr;
         low_ff  <= req_range_low;
         high_ff <= req_range_high;
         mask_ff <= req_value_mask;
      end
      state_ff <= state_in;
      value_ff <= value_in;
      try_ff   <= try_in;
      if (cmd.out_load) begin
         rsp_value_ff <= value_ff;
         rsp_state_ff <= state_ff;
      end
   end

   assign rsp_drawn_value    = rsp_value_ff;
   assign rsp_state_readback = rsp_state_ff;

endmodule

@@ sv/banked_xorshift_range_draw_core.sv @@
// ----------------------------------------------------------------------------
// banked_xorshift_range_draw_core: one request word at a time; a seed write is stored as accepted.
// rsp_valid rises once a read has passed LOAD and OUT, or a draw LOAD, its STEP states and OUT.
// The next request is taken once the core is back in IDLE; OUT holds while rsp_valid is unread.
// A draw does one xorshift step per cycle and gives up after 65536 steps with no response.
// Reset clears control state only; the state bank is undefined until seeded.
// ----------------------------------------------------------------------------
module banked_xorshift_range_draw_core #(
   parameter int STREAM_COUNT = bxrd_pkg::STREAM_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bxrd_pkg::FUNC_W-1:0]   req_func,
   input  logic [bxrd_pkg::INDEX_W-1:0]  req_stream_index,
   input  logic [bxrd_pkg::STATE_W-1:0]  req_seed_value,
   input  logic [bxrd_pkg::VALUE_W-1:0]  req_range_low,
   input  logic [bxrd_pkg::VALUE_W-1:0]  req_range_high,
   input  logic [bxrd_pkg::VALUE_W-1:0]  req_value_mask,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bxrd_pkg::VALUE_W-1:0]  rsp_drawn_value,
   output logic [bxrd_pkg::STATE_W-1:0]  rsp_state_readback
);

   bxrd_pkg::cmd_type    cmd;
   bxrd_pkg::status_type status;

   bxrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bxrd_dpath #(
      .STREAM_COUNT (STREAM_COUNT)
   ) u_dpath (
      .clock              (clock),
      .req_func           (req_func),
      .req_stream_index   (req_stream_index),
      .req_seed_value     (req_seed_value),
      .req_range_low      (req_range_low),
      .req_range_high     (req_range_high),
      .req_value_mask     (req_value_mask),
      .cmd                (cmd),
      .status             (status),
      .rsp_drawn_value    (rsp_drawn_value),
      .rsp_state_readback (rsp_state_readback)
   );

endmodule

@@ test/banked_xorshift_range_draw_core_tb.sv @@
// ----------------------------------------------------------------------------
// banked_xorshift_range_draw_core_tb
// Self-checking bench for the banked xorshift range draw core. A short table
// of directed words covers the field extremes, every function code, empty
// ranges, masks that miss the range and zero states. Random traffic follows,
// with draw ranges shaped so that most draws succeed. Every response word is
// checked against a bench-side model of the stream bank, and both channels
// idle in random bursts.
// ----------------------------------------------------------------------------
module banked_xorshift_range_draw_core_tb;

   localparam logic [bxrd_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
   localparam int STREAMS    = 32;
   localparam int DRAW_LIMIT = 1 << bxrd_pkg::TRY_W;
   localparam int WORDS      = 1350;
   localparam int CALM_WORDS = 150;
   localparam int PLAN_ROWS  = 21;
   localparam int WATCHDOG   = 280000;
   localparam int DRAIN      = 100;

   typedef struct packed {
      logic [bxrd_pkg::FUNC_W-1:0]  func;
      logic [bxrd_pkg::INDEX_W-1:0] idx;
      logic [bxrd_pkg::STATE_W-1:0] seed;
      logic [bxrd_pkg::VALUE_W-1:0] lo;
      logic [bxrd_pkg::VALUE_W-1:0] hi;
      logic [bxrd_pkg::VALUE_W-1:0] mask;
   } req_word_type;

   typedef struct packed {
      logic [bxrd_pkg::VALUE_W-1:0] value;
      logic [bxrd_pkg::STATE_W-1:0] state;
   } draw_out_type;

   typedef struct packed {
      req_word_type w;
      bit           typed;
      bit           has_out;
      draw_out_type out;
   } plan_row_type;

   logic                          clock              = 1'b0;
   logic                          reset              = 1'b1;
   logic                          req_valid          = 1'b0;
   logic                          req_ready;
   logic [bxrd_pkg::FUNC_W-1:0]   req_func           = bxrd_pkg::FUNC_SEED;
   logic [bxrd_pkg::INDEX_W-1:0]  req_stream_index   = '0;
   logic [bxrd_pkg::STATE_W-1:0]  req_seed_value     = '0;
   logic [bxrd_pkg::VALUE_W-1:0]  req_range_low      = '0;
   logic [bxrd_pkg::VALUE_W-1:0]  req_range_high     = '0;
   logic [bxrd_pkg::VALUE_W-1:0]  req_value_mask     = '0;
   logic                          rsp_valid;
   logic                          rsp_ready          = 1'b1;
   logic [bxrd_pkg::VALUE_W-1:0]  rsp_drawn_value;
   logic [bxrd_pkg::STATE_W-1:0]  rsp_state_readback;

   logic [bxrd_pkg::STATE_W-1:0]  bank [STREAMS];
   bit                            seeded [STREAMS];
   draw_out_type                  due_results [$];
   draw_out_type                  head;
   plan_row_type                  plan [PLAN_ROWS];
   int                            errors       = 0;
   int                            quiet_cycles = 0;
   int                            gap_pct      = 0;
   int                            stall_pct    = 0;
   int                            stall_left   = 0;
   int                            stall_epoch  = 0;
   bit                            calm         = 1'b0;

   banked_xorshift_range_draw_core #(
      .STREAM_COUNT(STREAMS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_stream_index(req_stream_index),
      .req_seed_value(req_seed_value),
      .req_range_low(req_range_low),
      .req_range_high(req_range_high),
      .req_value_mask(req_value_mask),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_drawn_value(rsp_drawn_value),
      .rsp_state_readback(rsp_state_readback)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Runs a draw from the given state; returns the step count of the hit, or -1
   // when no masked value falls in the range within the step limit.
   function automatic int draw_steps(input logic [bxrd_pkg::STATE_W-1:0] start,
                                     input logic [bxrd_pkg::VALUE_W-1:0] lo,
                                     input logic [bxrd_pkg::VALUE_W-1:0] hi,
                                     input logic [bxrd_pkg::VALUE_W-1:0] mask,
                                     input int limit,
                                     output logic [bxrd_pkg::VALUE_W-1:0] value,
                                     output logic [bxrd_pkg::STATE_W-1:0] fin);
      logic [bxrd_pkg::STATE_W-1:0] s;
      logic [bxrd_pkg::VALUE_W-1:0] v;
      int n;
      s = start;
      value = '0;
      for (n = 1; n <= limit; n++) begin
         s = s ^ (s << bxrd_pkg::SHIFT_A);
         s = s ^ (s >> bxrd_pkg::SHIFT_B);
         s = s ^ (s << bxrd_pkg::SHIFT_C);
         v = s[bxrd_pkg::VALUE_W-1:0] & mask;
         if (v >= lo && v <= hi) begin
            value = v;
            fin = s;
            return n;
         end
      end
      fin = s;
      return -1;
   endfunction

   task automatic send_word(input req_word_type w, input bit typed, input bit has_out,
                            input draw_out_type out);
      draw_out_type got;
      logic [bxrd_pkg::VALUE_W-1:0] v;
      logic [bxrd_pkg::STATE_W-1:0] s;
      bit has;
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= w.func;
      req_stream_index <= w.idx;
      req_seed_value   <= w.seed;
      req_range_low    <= w.lo;
      req_range_high   <= w.hi;
      req_value_mask   <= w.mask;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      has = 1'b0;
      got = '0;
      case (w.func)
         bxrd_pkg::FUNC_SEED: begin
            bank[w.idx] = w.seed;
            seeded[w.idx] = 1'b1;
         end
         bxrd_pkg::FUNC_READ: begin
            has = 1'b1;
            got.state = bank[w.idx];
         end
         bxrd_pkg::FUNC_DRAW: begin
            has = draw_steps(bank[w.idx], w.lo, w.hi, w.mask, DRAW_LIMIT, v, s) > 0;
            bank[w.idx] = s;
            got.value = v;
            got.state = s;
         end
         default: ;
      endcase
      if (typed) begin
         has = has_out;
         got = out;
      end
      if (has) due_results.push_back(got);
   endtask

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 9);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
      stall_epoch <= stall_epoch + 1;
      if (stall_epoch % 256 == 0) begin
         case ($urandom_range(0, 2))
            0:       stall_pct <= 0;
            1:       stall_pct <= 8;
            default: stall_pct <= 30;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("response word with none expected: drawn_value %h state_readback %h",
                      rsp_drawn_value, rsp_state_readback);
               errors++;
            end else begin
               head = due_results.pop_front();
               if (rsp_drawn_value !== head.value) begin
                  $error("drawn_value mismatch: expected %h, got %h",
                         head.value, rsp_drawn_value);
                  errors++;
               end
               if (rsp_state_readback !== head.state) begin
                  $error("state_readback mismatch: expected %h, got %h",
                         head.state, rsp_state_readback);
                  errors++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG) begin
            $display("banked_xorshift_range_draw_core test failed");
            $finish;
         end
      end
   end

   initial begin
      req_word_type w;
      draw_out_type none;
      logic [bxrd_pkg::VALUE_W-1:0] a, b, v;
      logic [bxrd_pkg::STATE_W-1:0] s;
      int counted, pick, k, tries;
      bit ok;

      none = '0;
      for (int i = 0; i < STREAMS; i++) begin
         bank[i] = '0;
         seeded[i] = 1'b0;
      end

      plan[0]  = '{'{bxrd_pkg::FUNC_SEED, 5'd0, 64'h1, 32'h0, 32'h0, 32'h0},
                   1'b0, 1'b0, none};
      plan[1]  = '{'{bxrd_pkg::FUNC_READ, 5'd0, 64'h0, 32'h0, 32'h0, 32'h0},
                   1'b1, 1'b1, '{32'h0, 64'h1}};
      plan[2]  = '{'{bxrd_pkg::FUNC_DRAW, 5'd0, 64'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                   1'b0, 1'b0, none};
      plan[3]  = '{'{bxrd_pkg::FUNC_SEED, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0,
                     32'h0}, 1'b0, 1'b0, none};
      plan[4]  = '{'{bxrd_pkg::FUNC_READ, 5'd31, 64'h0, 32'h0, 32'h0, 32'h0},
                   1'b1, 1'b1, '{32'h0, 64'hFFFF_FFFF_FFFF_FFFF}};
      plan[5]  = '{'{bxrd_pkg::FUNC_DRAW, 5'd31, 64'h0, 32'h0, 32'h0, 32'h0},
                   1'b0, 1'b0, none};
      plan[6]  = '{'{bxrd_pkg::FUNC_DRAW, 5'd31, 64'h0, 32'h8000_0000, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF}, 1'b0, 1'b0, none};
      // An empty range gives up after the full step budget with no response.
      plan[7]  = '{'{bxrd_pkg::FUNC_DRAW, 5'd0, 64'h0, 32'h5, 32'h4, 32'hFFFF_FFFF},
                   1'b1, 1'b0, none};
      plan[8]  = '{'{bxrd_pkg::FUNC_READ, 5'd0, 64'h0, 32'h0, 32'h0, 32'h0},
                   1'b0, 1'b0, none};
      plan[9]  = '{'{bxrd_pkg::FUNC_DRAW, 5'd31, 64'h0, 32'h100, 32'hFFFF, 32'h0000_000F},
                   1'b1, 1'b0, none};
      plan[10] = '{'{bxrd_pkg::FUNC_SEED, 5'd5, 64'h0, 32'h0, 32'h0, 32'h0},
                   1'b0, 1'b0, none};
      plan[11] = '{'{bxrd_pkg::FUNC_DRAW, 5'd5, 64'h0, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                   1'b1, 1'b0, none};
      plan[12] = '{'{bxrd_pkg::FUNC_DRAW, 5'd5, 64'h0, 32'h0, 32'h0, 32'hFFFF_FFFF},
                   1'b1, 1'b1, '{32'h0, 64'h0}};
      plan[13] = '{'{bxrd_pkg::FUNC_READ, 5'd5, 64'h0, 32'h0, 32'h0, 32'h0},
                   1'b1, 1'b1, '{32'h0, 64'h0}};
      plan[14] = '{'{FUNC_NONE, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF}, 1'b1, 1'b0, none};
      plan[15] = '{'{bxrd_pkg::FUNC_SEED, 5'd5, 64'h8000_0000_0000_0000, 32'h0, 32'h0,
                     32'h0}, 1'b0, 1'b0, none};
      plan[16] = '{'{bxrd_pkg::FUNC_DRAW, 5'd5, 64'h0, 32'h0, 32'h0, 32'hFFFF_FFFF},
                   1'b0, 1'b0, none};
      plan[17] = '{'{bxrd_pkg::FUNC_SEED, 5'd16, 64'hA5A5_A5A5_5A5A_5A5A, 32'h0, 32'h0,
                     32'h0}, 1'b0, 1'b0, none};
      plan[18] = '{'{bxrd_pkg::FUNC_READ, 5'd16, 64'h0, 32'h0, 32'h0, 32'h0},
                   1'b1, 1'b1, '{32'h0, 64'hA5A5_A5A5_5A5A_5A5A}};
      plan[19] = '{'{bxrd_pkg::FUNC_DRAW, 5'd16, 64'h0, 32'h0, 32'h0FFF_FFFF, 32'hFFFF_FFFF},
                   1'b0, 1'b0, none};
      plan[20] = '{'{bxrd_pkg::FUNC_READ, 5'd31, 64'h0, 32'h0, 32'h0, 32'h0},
                   1'b0, 1'b0, none};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++)
         send_word(plan[i].w, plan[i].typed, plan[i].has_out, plan[i].out);

      counted = 0;
      while (counted < WORDS) begin
         calm = (counted >= WORDS - CALM_WORDS);
         if (counted % 64 == 0) begin
            case ($urandom_range(0, 2))
               0:       gap_pct = 0;
               1:       gap_pct = 10;
               default: gap_pct = 35;
            endcase
         end
         w.idx  = (bxrd_pkg::INDEX_W)'($urandom_range(0, STREAMS - 1));
         w.seed = {$urandom, $urandom};
         w.lo   = $urandom;
         w.hi   = $urandom;
         w.mask = $urandom;
         pick   = $urandom_range(0, 99);
         if (pick < 5) begin
            w.func = FUNC_NONE;
         end else if (pick < 20 || !seeded[w.idx]) begin
            w.func = bxrd_pkg::FUNC_SEED;
            if (w.seed == '0) w.seed = 64'h1;
         end else if (pick < 45) begin
            w.func = bxrd_pkg::FUNC_READ;
         end else begin
            w.func = bxrd_pkg::FUNC_DRAW;
            ok = 1'b0;
            for (tries = 0; tries < 8 && !ok; tries++) begin
               case ($urandom_range(0, 3))
                  0: w.mask = '1;
                  1: begin
                     k = $urandom_range(0, 32);
                     w.mask = (k == 32) ? '1 : (32'h1 << k) - 32'h1;
                  end
                  default: w.mask = $urandom;
               endcase
               a = $urandom & w.mask;
               b = $urandom & w.mask;
               w.lo = (a < b) ? a : b;
               w.hi = (a < b) ? b : a;
               case ($urandom_range(0, 5))
                  0: w.lo = '0;
                  1: w.hi = '1;
                  2: begin
                     w.lo = $urandom;
                     w.hi = '1;
                  end
                  default: ;
               endcase
               ok = draw_steps(bank[w.idx], w.lo, w.hi, w.mask, 1024, v, s) > 0;
            end
            if (!ok) begin
               w.lo = '0;
               w.hi = '1;
            end
         end
         send_word(w, 1'b0, 1'b0, none);
         if (w.func != FUNC_NONE) counted++;
      end

      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0)
         $display("banked_xorshift_range_draw_core test passed");
      else
         $display("banked_xorshift_range_draw_core test failed");
      $finish;
   end

endmodule
